@@ sv/des_ks_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, DES permutation tables and bit-selection helpers for the DES key schedule.
// No dependencies; every other file of the block imports this package.
package des_ks_pkg;

    localparam int KEY_W       = 56;
    localparam int HALF_W      = 28;
    localparam int SUBKEY_W    = 48;
    localparam int ROUND_W     = 4;
    localparam int NUM_ROUNDS  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [KEY_W-1:0]    cd_t;
    typedef logic [HALF_W-1:0]   half_t;
    typedef logic [SUBKEY_W-1:0] subkey_t;
    typedef logic [ROUND_W-1:0]  round_t;

    localparam round_t LAST_ROUND = round_t'(NUM_ROUNDS - 1);

    // Status of the queue between the front and the back.
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    // PC-1, positions in the 64-bit parity-expanded key.
    localparam logic [5:0] PC1_TAB [56] = '{
        6'd57, 6'd49, 6'd41, 6'd33, 6'd25, 6'd17, 6'd9,
        6'd1,  6'd58, 6'd50, 6'd42, 6'd34, 6'd26, 6'd18,
        6'd10, 6'd2,  6'd59, 6'd51, 6'd43, 6'd35, 6'd27,
        6'd19, 6'd11, 6'd3,  6'd60, 6'd52, 6'd44, 6'd36,
        6'd63, 6'd55, 6'd47, 6'd39, 6'd31, 6'd23, 6'd15,
        6'd7,  6'd62, 6'd54, 6'd46, 6'd38, 6'd30, 6'd22,
        6'd14, 6'd6,  6'd61, 6'd53, 6'd45, 6'd37, 6'd29,
        6'd21, 6'd13, 6'd5,  6'd28, 6'd20, 6'd12, 6'd4
    };

    // PC-2, positions in the 56-bit C||D word.
    localparam logic [5:0] PC2_TAB [48] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
        6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
        6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
        6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
        6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
        6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    // Left rotation per round.
    localparam logic [1:0] ROT_TAB [16] = '{
        2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
    };

    // PC-1 applied to the 56 key bits. The parity positions of the expanded
    // key are never selected, so the expanded position maps straight back.
    function automatic cd_t pc1(input key_t key);
        cd_t cd;
        int  z;
        int  k;
        cd = '0;
        for (int i = 0; i < KEY_W; i++) begin
            z = int'(PC1_TAB[i]) - 1;
            k = z - (z >> 3);
            cd[KEY_W-1-i] = key[KEY_W-1-k];
        end
        return cd;
    endfunction

    // PC-2 applied to C||D, DES bit 1 most significant.
    function automatic subkey_t pc2(input cd_t cd);
        subkey_t sk;
        sk = '0;
        for (int i = 0; i < SUBKEY_W; i++) begin
            sk[SUBKEY_W-1-i] = cd[KEY_W - int'(PC2_TAB[i])];
        end
        return sk;
    endfunction

    // Rotate a 28-bit half left by one or two places.
    function automatic half_t rotl(input half_t v, input logic [1:0] s);
        half_t r;
        if (s == 2'd2) begin
            r = {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]};
        end
        else begin
            r = {v[HALF_W-2:0], v[HALF_W-1]};
        end
        return r;
    endfunction

endpackage

@@ sv/des_ks_front.sv @@
`timescale 1ns / 1ps
// Front stage: accepts a key word, applies PC-1 and hands C||D to the queue.
// Depends on des_ks_pkg.
module des_ks_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  des_ks_pkg::key_t    key_bits,
    output logic                full,
    input  logic                q_full,
    output logic                q_push,
    output des_ks_pkg::cd_t     q_data
);
    import des_ks_pkg::*;

    logic valid_reg;
    logic valid_next;
    cd_t  cd_reg;
    logic accept;

    assign q_push = valid_reg && !q_full;
    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_data = cd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end
        else if (q_push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            cd_reg <= pc1(key_bits);
        end
    end

endmodule

@@ sv/des_ks_queue.sv @@
`timescale 1ns / 1ps
// Short register queue of C||D words between the front and the back stage.
// Depends on des_ks_pkg.
module des_ks_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  des_ks_pkg::cd_t           wr_data,
    input  logic                      rd_en,
    output des_ks_pkg::cd_t           rd_data,
    output des_ks_pkg::queue_status_t status
);
    import des_ks_pkg::*;

    cd_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_wr;
    logic              do_rd;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ sv/des_ks_back.sv @@
`timescale 1ns / 1ps
// Back stage: steps sixteen rounds of rotation and PC-2 into an output register.
// Depends on des_ks_pkg.
module des_ks_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  des_ks_pkg::queue_status_t q_status,
    input  des_ks_pkg::cd_t           q_data,
    output logic                      q_pop,
    input  logic                      pop,
    output logic                      empty,
    output des_ks_pkg::round_t        round_index,
    output des_ks_pkg::subkey_t       subkey,
    output logic                      last_round
);
    import des_ks_pkg::*;

    logic    busy_reg;
    logic    busy_next;
    half_t   c_reg;
    half_t   d_reg;
    round_t  round_reg;
    round_t  round_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    round_t  out_round_reg;
    subkey_t out_subkey_reg;
    logic    out_last_reg;

    half_t   c_cur;
    half_t   d_cur;
    round_t  r_cur;
    half_t   c_rot;
    half_t   d_rot;
    logic    advance;

    // When idle, round one starts straight from the queue head.
    assign c_cur   = busy_reg ? c_reg : q_data[KEY_W-1:HALF_W];
    assign d_cur   = busy_reg ? d_reg : q_data[HALF_W-1:0];
    assign r_cur   = busy_reg ? round_reg : '0;
    assign c_rot   = rotl(c_cur, ROT_TAB[r_cur]);
    assign d_rot   = rotl(d_cur, ROT_TAB[r_cur]);
    assign advance = (busy_reg || !q_status.empty) && (!out_valid_reg || pop);
    assign q_pop   = advance && !busy_reg;

    assign empty       = !out_valid_reg;
    assign round_index = out_round_reg;
    assign subkey      = out_subkey_reg;
    assign last_round  = out_last_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && pop) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
            busy_next      = (r_cur != LAST_ROUND);
            round_next     = r_cur + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            busy_reg      <= busy_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            c_reg          <= c_rot;
            d_reg          <= d_rot;
            out_round_reg  <= r_cur;
            out_subkey_reg <= pc2({c_rot, d_rot});
            out_last_reg   <= (r_cur == LAST_ROUND);
        end
    end

endmodule

@@ sv/des_key_schedule.sv @@
`timescale 1ns / 1ps
// DES key schedule top level: front stage, C||D queue and round stage.
// Depends on des_ks_pkg, des_ks_front, des_ks_queue and des_ks_back.
//
// Usage. Both sides behave like a queue. A 56-bit key word (eight 7-bit
// groups, first group most significant) is taken at a rising edge where
// push is high and full is low. Each key produces sixteen result words,
// one per round in order: round_index (0 for round one), the 48-bit PC-2
// subkey with DES bit 1 as MSB, and last_round, high on the sixteenth.
// The oldest result is on the result ports while empty is low and is
// taken at an edge where pop is high.
//
// Path: the accepting edge loads the front register; the key's C||D then
// is written into the queue and from there loads the round stage output
// register with the first subkey. Either step waits while the queue is
// full or the output register holds a word that has not been popped.
// Throughput: one subkey per cycle while pop keeps the result register
// drained; the round stage, which rotates C and D once per subkey, sets
// that rate. The front holds one key and the queue two more, so up to
// three keys can be taken ahead of the round stage.
//
// Reset clears all valid flags, pointers and the round counter: empty goes
// high and full goes low. When the receiver stalls, the result word holds,
// the round stage waits, and full rises once the queue and front fill up.
module des_key_schedule (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  des_ks_pkg::key_t     key_bits,
    input  logic                 pop,
    output logic                 empty,
    output des_ks_pkg::round_t   round_index,
    output des_ks_pkg::subkey_t  subkey,
    output logic                 last_round
);
    import des_ks_pkg::*;

    queue_status_t q_status;
    logic          q_push;
    cd_t           q_wdata;
    logic          q_pop;
    cd_t           q_rdata;

    // The front permutes the key with PC-1 and parks C||D until the
    // queue has room.
    des_ks_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .key_bits (key_bits),
        .full     (full),
        .q_full   (q_status.full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    // The queue decouples key intake from the round walk.
    des_ks_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .status  (q_status)
    );

    // The back walks the rounds and drives the result word register.
    des_ks_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .round_index (round_index),
        .subkey      (subkey),
        .last_round  (last_round)
    );

    // The front only pushes into a queue with room.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
    else $error("push into a full queue");

    // last_round marks exactly the final round.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_round == (round_index == LAST_ROUND)))
    else $error("last_round does not match round_index");

    // Within a key, rounds follow one another.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_round) |=>
            (empty || (round_index == $past(round_index) + 1'b1)))
    else $error("round sequence broken");

    // After the last round, the next word starts a new key at round one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && last_round) |=> (empty || (round_index == '0)))
    else $error("new key did not start at round one");

endmodule
